FILE: rtl/tii_pkg.sv
// ----------------------------------------------------------------------------
// tii_pkg
// Shared sizes, codes and types of the table inverse interpolator.
// ----------------------------------------------------------------------------
package tii_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(DATA_WIDTH);
    localparam int STAT_W      = 2;

    localparam logic [IDX_W-1:0] LAST_MAX   = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0] LAST_RESET = IDX_W'(TABLE_DEPTH - 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        CLAMP_INTERIOR = 2'd0,
        CLAMP_BELOW    = 2'd1,
        CLAMP_ABOVE    = 2'd2
    } t_clamp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_SEARCH,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/tii_if.sv
// ----------------------------------------------------------------------------
// tii_in_if / tii_out_if
// Valid/ready channels for command items and interpolation results.
// ----------------------------------------------------------------------------
interface tii_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [tii_pkg::IDX_W-1:0]        entry_index;
    logic [tii_pkg::DATA_WIDTH-1:0]   entry_key;
    logic [tii_pkg::DATA_WIDTH-1:0]   entry_value;
    logic [tii_pkg::DATA_WIDTH-1:0]   query_key;

    modport source (
        output valid, cmd, entry_index, entry_key, entry_value, query_key,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, entry_key, entry_value, query_key,
        output ready
    );
endinterface

interface tii_out_if;
    logic                             valid;
    logic                             ready;
    logic [tii_pkg::DATA_WIDTH-1:0]   result_value;
    logic [tii_pkg::STAT_W-1:0]       clamp_status;

    modport source (
        output valid, result_value, clamp_status,
        input  ready
    );
    modport sink (
        input  valid, result_value, clamp_status,
        output ready
    );
endinterface

FILE: rtl/table_inverse_interpolator_top.sv
// ----------------------------------------------------------------------------
// table_inverse_interpolator_top
// Breakpoint table with clamped, piecewise-linear interpolation of a key.
// ----------------------------------------------------------------------------
// The block holds up to 1024 breakpoints (key, value), unsigned Q8.24, written
// one per load transfer; a load returns nothing. A query transfer returns one
// result: the first value with status 1 when the key is at or below the first
// key, the value at last_index with status 2 when it is at or above that key,
// else a linear interpolation (truncated toward the lower value's side) with
// status 0. The table must be nondecreasing and every entry a query touches
// must have been written. A query clamped below ends after the check of the
// first key and one clamped above after the check of the last key; an interior
// query goes on with a binary search over registered reads of the table
// memories, reads the lower and upper entries and forms the step in the
// bit-serial scaled divider. One item is in work at a time; a finished result
// waits in the output register, so the next item can be taken while the
// previous result is not yet collected. last_index is written through
// i_cfg_wr_en/i_cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce; 0 acts as 1.
// ----------------------------------------------------------------------------
module table_inverse_interpolator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tii_in_if.sink                     i_in,
    tii_out_if.source                  o_out,
    input  logic                       i_cfg_wr_en,
    input  logic [tii_pkg::IDX_W-1:0]  i_cfg_wr_data
);

    localparam int DW = tii_pkg::DATA_WIDTH;
    localparam int IW = tii_pkg::IDX_W;

    tii_pkg::t_state  r_state;
    tii_pkg::t_state  n_state;

    // Configuration and its effective value.
    logic [IW-1:0]    r_last;
    logic [IW-1:0]    w_last;

    // Table memories, read with a registered port.
    logic [DW-1:0]    r_key_mem [tii_pkg::TABLE_DEPTH];
    logic [DW-1:0]    r_val_mem [tii_pkg::TABLE_DEPTH];
    logic [DW-1:0]    r_kd;
    logic [DW-1:0]    r_vd;
    logic [IW-1:0]    n_addr;

    // Query working registers.
    logic [DW-1:0]    r_q;
    logic [DW-1:0]    n_q;
    logic [IW:0]      r_lo;
    logic [IW:0]      n_lo;
    logic [IW-1:0]    r_hi;
    logic [IW-1:0]    n_hi;
    logic [IW-1:0]    r_mid;
    logic [IW-1:0]    n_mid;
    logic [IW-1:0]    r_k;
    logic [IW-1:0]    n_k;
    logic [DW-1:0]    r_k0;
    logic [DW-1:0]    n_k0;
    logic [DW-1:0]    r_v0;
    logic [DW-1:0]    n_v0;
    logic             r_neg;
    logic             n_neg;
    logic [DW-1:0]    r_res;
    logic [DW-1:0]    n_res;
    tii_pkg::t_clamp  r_stat;
    tii_pkg::t_clamp  n_stat;

    // Output register.
    logic             r_out_valid;
    logic [DW-1:0]    r_out_res;
    tii_pkg::t_clamp  r_out_stat;
    logic             w_out_free;
    logic             w_out_load;

    // Handshake decode.
    logic             w_accept;
    logic             w_load;
    logic             w_query;

    // Search step.
    logic             w_lt;
    logic [IW:0]      w_lo_nx;
    logic [IW-1:0]    w_hi_nx;
    logic [IW:0]      w_sum_nx;
    logic [IW:0]      w_sum_first;
    logic             w_stop;
    logic [IW-1:0]    w_k;

    // Bracket check and divider hookup.
    logic             w_bad;
    logic             w_div_start;
    logic             w_div_done;
    logic [DW-1:0]    w_div_a;
    logic [DW-1:0]    w_div_d;
    logic [DW-1:0]    w_div_b;
    logic [DW-1:0]    w_quot;

    assign i_in.ready = (r_state == tii_pkg::ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = w_accept && (i_in.cmd == tii_pkg::CMD_LOAD)
                        && (i_in.entry_index <= tii_pkg::LAST_MAX);
    assign w_query    = w_accept && (i_in.cmd == tii_pkg::CMD_QUERY);

    // A last index of zero behaves as one; anything past the table as its end.
    always_comb begin
        if (r_last == '0) begin
            w_last = IW'(1);
        end else if (r_last > tii_pkg::LAST_MAX) begin
            w_last = tii_pkg::LAST_MAX;
        end else begin
            w_last = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= tii_pkg::LAST_RESET;
        end else if (i_cfg_wr_en) begin
            r_last <= i_cfg_wr_data;
        end
    end

    // Memories: loads write at the transfer, every cycle reads at n_addr.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key_mem[i_in.entry_index] <= i_in.entry_key;
            r_val_mem[i_in.entry_index] <= i_in.entry_value;
        end
        r_kd <= r_key_mem[n_addr];
        r_vd <= r_val_mem[n_addr];
    end

    // One binary search step on the entry just read at r_mid. The search
    // looks for the first entry at or above the query key; the low bound can
    // run one past the last index, which the clamp on w_k folds back.
    assign w_lt        = (r_kd < r_q);
    assign w_lo_nx     = w_lt ? ({1'b0, r_mid} + 1'b1) : r_lo;
    assign w_hi_nx     = w_lt ? r_hi : (r_mid - 1'b1);
    assign w_stop      = (w_lo_nx > {1'b0, w_hi_nx});
    assign w_sum_nx    = w_lo_nx + {1'b0, w_hi_nx};
    assign w_sum_first = {1'b0, w_last} + 1'b1;
    assign w_k         = (w_lo_nx > {1'b0, w_last}) ? w_last : w_lo_nx[IW-1:0];

    // In ST_RD_HI the upper entry sits in r_kd/r_vd and the lower one in
    // r_k0/r_v0. A broken bracket falls back to the lower value.
    assign w_bad   = (r_kd <= r_k0) || (r_q <= r_k0) || (r_q > r_kd);
    assign w_div_a = r_q - r_k0;
    assign w_div_b = r_kd - r_k0;
    assign w_div_d = (r_vd < r_v0) ? (r_v0 - r_vd) : (r_vd - r_v0);

    assign w_out_free = !r_out_valid || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tii_pkg::ST_IDLE: begin
                if (w_query) begin
                    n_state = tii_pkg::ST_CHK_FIRST;
                end
            end
            tii_pkg::ST_CHK_FIRST: begin
                if (r_q <= r_kd) begin
                    n_state = tii_pkg::ST_DONE;
                end else begin
                    n_state = tii_pkg::ST_CHK_LAST;
                end
            end
            tii_pkg::ST_CHK_LAST: begin
                if (r_q >= r_kd) begin
                    n_state = tii_pkg::ST_DONE;
                end else begin
                    n_state = tii_pkg::ST_SEARCH;
                end
            end
            tii_pkg::ST_SEARCH: begin
                if (w_stop) begin
                    n_state = tii_pkg::ST_RD_LO;
                end
            end
            tii_pkg::ST_RD_LO: begin
                n_state = tii_pkg::ST_RD_HI;
            end
            tii_pkg::ST_RD_HI: begin
                if (w_bad) begin
                    n_state = tii_pkg::ST_DONE;
                end else begin
                    n_state = tii_pkg::ST_DIV;
                end
            end
            tii_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = tii_pkg::ST_DONE;
                end
            end
            tii_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = tii_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tii_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: memory address, datapath updates, divider start.
    always_comb begin
        n_addr      = '0;
        n_q         = r_q;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_k         = r_k;
        n_k0        = r_k0;
        n_v0        = r_v0;
        n_neg       = r_neg;
        n_res       = r_res;
        n_stat      = r_stat;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            tii_pkg::ST_IDLE: begin
                n_q    = i_in.query_key;
                n_addr = '0;
            end
            tii_pkg::ST_CHK_FIRST: begin
                n_res  = r_vd;
                n_stat = tii_pkg::CLAMP_BELOW;
                n_addr = w_last;
            end
            tii_pkg::ST_CHK_LAST: begin
                n_res  = r_vd;
                n_stat = tii_pkg::CLAMP_ABOVE;
                n_lo   = (IW + 1)'(1);
                n_hi   = w_last;
                n_mid  = w_sum_first[IW:1];
                n_addr = w_sum_first[IW:1];
            end
            tii_pkg::ST_SEARCH: begin
                n_lo  = w_lo_nx;
                n_hi  = w_hi_nx;
                n_mid = w_sum_nx[IW:1];
                if (w_stop) begin
                    n_k    = w_k;
                    n_addr = w_k - 1'b1;
                end else begin
                    n_addr = w_sum_nx[IW:1];
                end
            end
            tii_pkg::ST_RD_LO: begin
                n_k0   = r_kd;
                n_v0   = r_vd;
                n_addr = r_k;
            end
            tii_pkg::ST_RD_HI: begin
                n_neg       = (r_vd < r_v0);
                n_res       = r_v0;
                n_stat      = tii_pkg::CLAMP_INTERIOR;
                w_div_start = !w_bad;
            end
            tii_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_res = r_neg ? (r_v0 - w_quot) : (r_v0 + w_quot);
                end
            end
            tii_pkg::ST_DONE: begin
                w_out_load = w_out_free;
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tii_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_k    <= n_k;
        r_k0   <= n_k0;
        r_v0   <= n_v0;
        r_neg  <= n_neg;
        r_res  <= n_res;
        r_stat <= n_stat;
    end

    tii_scaled_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_a     (w_div_a),
        .i_d     (w_div_d),
        .i_b     (w_div_b),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // The output register holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_res  <= r_res;
            r_out_stat <= r_stat;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_res;
    assign o_out.clamp_status = r_out_stat;

endmodule

FILE: rtl/tii_scaled_div.sv
// ----------------------------------------------------------------------------
// tii_scaled_div
// Bit-serial floor(a * d / b) for a < b, one bit of d per cycle.
// ----------------------------------------------------------------------------
module tii_scaled_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tii_pkg::DATA_WIDTH-1:0] i_a,
    input  logic [tii_pkg::DATA_WIDTH-1:0] i_d,
    input  logic [tii_pkg::DATA_WIDTH-1:0] i_b,
    output logic                           o_done,
    output logic [tii_pkg::DATA_WIDTH-1:0] o_quot
);

    localparam int DW = tii_pkg::DATA_WIDTH;

    logic                       r_busy;
    logic                       r_done;
    logic [tii_pkg::CNT_W-1:0]  r_cnt;
    logic [DW-1:0]              r_a;
    logic [DW-1:0]              r_b;
    logic [DW-1:0]              r_d;
    logic [DW-1:0]              r_rem;
    logic [DW-1:0]              r_quot;

    logic [DW+1:0]              w_t;
    logic [DW+1:0]              w_b1;
    logic [DW+1:0]              w_b2;
    logic                       w_ge1;
    logic                       w_ge2;
    logic [1:0]                 w_digit;
    logic [DW+1:0]              w_rem_n;

    // The partial remainder stays below b, so 2r + a stays below 3b and
    // each step yields a quotient digit of 0, 1 or 2.
    assign w_t   = {1'b0, r_rem, 1'b0} + (r_d[DW-1] ? {2'b00, r_a} : '0);
    assign w_b1  = {2'b00, r_b};
    assign w_b2  = {1'b0, r_b, 1'b0};
    assign w_ge1 = (w_t >= w_b1);
    assign w_ge2 = (w_t >= w_b2);

    always_comb begin
        if (w_ge2) begin
            w_digit = 2'd2;
            w_rem_n = w_t - w_b2;
        end else if (w_ge1) begin
            w_digit = 2'd1;
            w_rem_n = w_t - w_b1;
        end else begin
            w_digit = 2'd0;
            w_rem_n = w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= tii_pkg::CNT_W'(DW - 1);
            r_a    <= i_a;
            r_b    <= i_b;
            r_d    <= i_d;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_d    <= {r_d[DW-2:0], 1'b0};
            r_rem  <= w_rem_n[DW-1:0];
            r_quot <= {r_quot[DW-2:0], 1'b0} + DW'(w_digit);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/tii_checker.sv
// ----------------------------------------------------------------------------
// tii_checker
// Port-level checks of the table inverse interpolator, bound to the top.
// ----------------------------------------------------------------------------
module tii_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_cmd,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tii_pkg::DATA_WIDTH-1:0] i_out_result_value,
    input logic [tii_pkg::STAT_W-1:0]     i_out_clamp_status
);

    // Reset empties the output register.
    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result still offered after reset");

    // A load leaves the block idle: it is ready again right after.
    a_load_one_cycle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_cmd == tii_pkg::CMD_LOAD)) |=> i_in_ready)
        else $error("block not ready after a load transfer");

    // A query occupies the block for at least the next cycle.
    a_query_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_cmd == tii_pkg::CMD_QUERY)) |=> !i_in_ready)
        else $error("block ready right after a query transfer");

    // A stalled result holds.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_result_value) && $stable(i_out_clamp_status)))
        else $error("stalled result changed");

endmodule

bind table_inverse_interpolator_top tii_checker u_tii_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_cmd           (i_in.cmd),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_result_value (o_out.result_value),
    .i_out_clamp_status (o_out.clamp_status)
);
